FILE: design/svpwm_pkg.sv
// Shared constants, types and the sine table of the SVPWM duty core.
package svpwm_pkg;

   // Format constants
   localparam int ANGLE_BITS      = 16;
   localparam int SINE_TABLE_BITS = 10;
   localparam int DUTY_FRAC_BITS  = 15;

   // Port widths
   localparam int UQ_W    = 16;
   localparam int ANGLE_W = 16;
   localparam int BUS_W   = 16;
   localparam int DUTY_W  = 16;

   localparam logic [BUS_W-1:0] BUS_RESET = BUS_W'(12000);

   // Q30 constants
   localparam int Q_FRAC   = 30;
   localparam int SQRT3_W  = 31;
   localparam logic [SQRT3_W-1:0] SQRT3_Q30 = SQRT3_W'(1859775393);
   localparam longint unsigned PI3_Q30 = 64'd1124419809;
   localparam int SINE_W   = Q_FRAC;

   // Angle datapath
   localparam int ANG_EXT_W = (ANGLE_BITS > ANGLE_W) ? ANGLE_BITS : ANGLE_W;
   localparam int A6_W      = ANGLE_BITS + 3;
   localparam logic [ANGLE_BITS-1:0] ANGLE_QUARTER = {2'b01, {(ANGLE_BITS-2){1'b0}}};
   localparam logic [ANGLE_BITS-1:0] ANGLE_HALF    = {2'b10, {(ANGLE_BITS-2){1'b0}}};

   // Sine ROM
   localparam int ROM_DEPTH  = (1 << SINE_TABLE_BITS) + 1;
   localparam int ROM_ADDR_W = SINE_TABLE_BITS + 1;
   localparam logic [ROM_ADDR_W-1:0] ROM_TOP = {1'b1, {SINE_TABLE_BITS{1'b0}}};

   // Magnitude and divider
   localparam int MAG_W      = UQ_W + 1;
   localparam int MAGSQ_W    = 2 * MAG_W;
   localparam int TRIPLE_W   = MAGSQ_W + 2;
   localparam int BUSSQ_W    = 2 * BUS_W;
   localparam int DVD_W      = MAG_W + SQRT3_W;
   localparam int QUO_W      = DVD_W - BUS_W;
   localparam int DIV_STEP   = 4;
   localparam int DIV_STAGES = QUO_W / DIV_STEP;

   // Ratio and duty datapath
   localparam int PROD_W     = QUO_W + SINE_W;
   localparam int R_SHIFT    = 2 * Q_FRAC - DUTY_FRAC_BITS;
   localparam int R_W        = DUTY_FRAC_BITS + 1;
   localparam int SUM_W      = R_W + 2;
   localparam int DUTY_EXT_W = (R_W > DUTY_W) ? R_W : DUTY_W;
   localparam logic [R_W-1:0] DUTY_ONE = {1'b1, {DUTY_FRAC_BITS{1'b0}}};

   // Accept edge to the edge that samples the strobe
   localparam int RSP_LATENCY = DIV_STAGES + 6;

   typedef enum logic [2:0] {
      SEC_1 = 3'd0,
      SEC_2 = 3'd1,
      SEC_3 = 3'd2,
      SEC_4 = 3'd3,
      SEC_5 = 3'd4,
      SEC_6 = 3'd5
   } sector_type;

   // Sideband carried alongside the divider
   typedef struct packed {
      logic              fault;
      sector_type        sector;
      logic [SINE_W-1:0] sin1;
      logic [SINE_W-1:0] sin2;
   } div_side_type;

   typedef logic [SINE_W-1:0] sine_rom_type [ROM_DEPTH];

   // Taylor divisors (2k)(2k+1), k = 1..7
   localparam longint unsigned TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                   64'd110, 64'd156, 64'd210};

   // Truncating eight-term Taylor sine over [0, pi/3], built at elaboration
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type    rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      for (int j = 0; j < ROM_DEPTH; j++) begin
         x    = (64'(j) * PI3_Q30) >> SINE_TABLE_BITS;
         x2   = (x * x) >> Q_FRAC;
         term = x;
         sum  = x;
         for (int k = 1; k <= 7; k++) begin
            term = (term * x2) >> Q_FRAC;
            term = term / TAYLOR_DIV[k];
            if ((k % 2) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         rom[j] = sum[SINE_W-1:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

FILE: design/svpwm_div.sv
// Pipelined restoring divider for the modulation ratio, four quotient bits per stage.
module svpwm_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic [svpwm_pkg::DVD_W-1:0]        in_dividend,
   input  logic [svpwm_pkg::BUS_W-1:0]        divisor,
   input  svpwm_pkg::div_side_type            in_side,
   output logic                               out_valid,
   output logic [svpwm_pkg::QUO_W-1:0]        out_quotient,
   output svpwm_pkg::div_side_type            out_side
);

   logic                          valid_ff [svpwm_pkg::DIV_STAGES];
   logic [svpwm_pkg::BUS_W-1:0]   rem_ff   [svpwm_pkg::DIV_STAGES];
   logic [svpwm_pkg::QUO_W-1:0]   work_ff  [svpwm_pkg::DIV_STAGES];
   svpwm_pkg::div_side_type       side_ff  [svpwm_pkg::DIV_STAGES];

   for (genvar s = 0; s < svpwm_pkg::DIV_STAGES; s++) begin : g_stage
      logic                        valid_src;
      logic [svpwm_pkg::BUS_W-1:0] rem_src;
      logic [svpwm_pkg::QUO_W-1:0] work_src;
      svpwm_pkg::div_side_type     side_src;
      logic [svpwm_pkg::BUS_W-1:0] rem_in;
      logic [svpwm_pkg::QUO_W-1:0] work_in;
      logic [svpwm_pkg::BUS_W:0]   trial;

      // First stage loads the high dividend bits as the partial remainder
      if (s == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = in_dividend[svpwm_pkg::DVD_W-1:svpwm_pkg::QUO_W];
         assign work_src  = in_dividend[svpwm_pkg::QUO_W-1:0];
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[s-1];
         assign rem_src   = rem_ff[s-1];
         assign work_src  = work_ff[s-1];
         assign side_src  = side_ff[s-1];
      end

      // Shift-subtract steps; quotient bits shift in from the bottom
      always_comb begin
         rem_in  = rem_src;
         work_in = work_src;
         trial   = '0;
         for (int b = 0; b < svpwm_pkg::DIV_STEP; b++) begin
            trial = {rem_in, work_in[svpwm_pkg::QUO_W-1]};
            if (trial >= {1'b0, divisor}) begin
               rem_in  = svpwm_pkg::BUS_W'(trial - {1'b0, divisor});
               work_in = {work_in[svpwm_pkg::QUO_W-2:0], 1'b1};
            end else begin
               rem_in  = trial[svpwm_pkg::BUS_W-1:0];
               work_in = {work_in[svpwm_pkg::QUO_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in;
         work_ff[s] <= work_in;
         side_ff[s] <= side_src;
      end
   end

   assign out_valid    = valid_ff[svpwm_pkg::DIV_STAGES-1];
   assign out_quotient = work_ff[svpwm_pkg::DIV_STAGES-1];
   assign out_side     = side_ff[svpwm_pkg::DIV_STAGES-1];

endmodule

FILE: design/svpwm_duty_from_uq_angle_core.sv
// Seven-segment SVPWM duty core: q-axis voltage and rotor angle in, three phase duties out.
//
// Request: drive req_uq and req_angle with start high; the word is taken at a rising
// edge where start is high and busy is low. busy is low at all times except the cycle
// after reset, so a new word may be taken every cycle.
// Response: rsp_strobe is high for exactly one cycle per request, with rsp_duty_a/b/c
// and rsp_valid_res. Each word passes through the angle and ROM stages, the 8-stage
// modulation-ratio divider (4 quotient bits per stage) and the ratio multiply,
// zero-time and duty-table stages.
// Results come out in request order. The receiver has no way to hold a result off.
// Throughput: one word per cycle, sustained.
// Config: csr_bus_voltage is written on csr_valid with csr_ready (always high); write
// only while no request is in flight. A bus voltage of zero flags every result invalid.
// Reset (synchronous, active high) empties the pipeline, sets the bus voltage to 12000
// mV and holds busy high for one cycle after release.
module svpwm_duty_from_uq_angle_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [svpwm_pkg::UQ_W-1:0]   req_uq,
   input  logic [svpwm_pkg::ANGLE_W-1:0]       req_angle,
   output logic                                rsp_strobe,
   output logic [svpwm_pkg::DUTY_W-1:0]        rsp_duty_a,
   output logic [svpwm_pkg::DUTY_W-1:0]        rsp_duty_b,
   output logic [svpwm_pkg::DUTY_W-1:0]        rsp_duty_c,
   output logic                                rsp_valid_res,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [svpwm_pkg::BUS_W-1:0]         csr_bus_voltage
);

   localparam int AB  = svpwm_pkg::ANGLE_BITS;
   localparam int STB = svpwm_pkg::SINE_TABLE_BITS;

   // Clamp to 1.0, then fit to the duty port width
   function automatic logic [svpwm_pkg::DUTY_W-1:0] fit_duty(
      input logic [svpwm_pkg::SUM_W-1:0] v
   );
      logic [svpwm_pkg::R_W-1:0]        c;
      logic [svpwm_pkg::DUTY_EXT_W-1:0] e;
      if (v > svpwm_pkg::SUM_W'(svpwm_pkg::DUTY_ONE)) begin
         c = svpwm_pkg::DUTY_ONE;
      end else begin
         c = v[svpwm_pkg::R_W-1:0];
      end
      e = svpwm_pkg::DUTY_EXT_W'(c);
      return e[svpwm_pkg::DUTY_W-1:0];
   endfunction

   // Control and config registers
   logic                        busy_ff;
   logic [svpwm_pkg::BUS_W-1:0] bus_ff;
   logic [svpwm_pkg::BUSSQ_W-1:0] bus_sq_ff;
   logic                        accept;

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         bus_ff  <= svpwm_pkg::BUS_RESET;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            bus_ff <= csr_bus_voltage;
         end
      end
   end

   // Bus squared for the range check, registered from the bus voltage register
   always_ff @(posedge clock) begin
      bus_sq_ff <= svpwm_pkg::BUSSQ_W'(bus_ff) * svpwm_pkg::BUSSQ_W'(bus_ff);
   end

   // ---------------- Stage 1: magnitude and rotated angle ----------------
   logic                         s1_valid_ff;
   logic [svpwm_pkg::MAG_W-1:0]  s1_mag_ff;
   logic [AB-1:0]                s1_angle_ff;
   logic [svpwm_pkg::MAG_W-1:0]  s1_mag_in;
   logic [AB-1:0]                s1_angle_in;
   logic [svpwm_pkg::ANG_EXT_W-1:0] angle_ext;
   logic                         uq_neg;

   always_comb begin
      uq_neg    = req_uq[svpwm_pkg::UQ_W-1];
      angle_ext = svpwm_pkg::ANG_EXT_W'(req_angle);
      if (uq_neg) begin
         s1_mag_in = svpwm_pkg::MAG_W'(0) - svpwm_pkg::MAG_W'(req_uq);
      end else begin
         s1_mag_in = svpwm_pkg::MAG_W'(req_uq);
      end
      // Quarter turn, plus a half turn for a negative command
      s1_angle_in = angle_ext[AB-1:0] + svpwm_pkg::ANGLE_QUARTER
                  + (uq_neg ? svpwm_pkg::ANGLE_HALF : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_mag_ff   <= s1_mag_in;
      s1_angle_ff <= s1_angle_in;
   end

   // ---------------- Stage 2: sector, ROM index, products ----------------
   logic                           s2_valid_ff;
   svpwm_pkg::sector_type          s2_sector_ff;
   logic [STB-1:0]                 s2_idx_ff;
   logic [svpwm_pkg::DVD_W-1:0]    s2_dividend_ff;
   logic [svpwm_pkg::MAGSQ_W-1:0]  s2_magsq_ff;
   logic [svpwm_pkg::A6_W-1:0]     a6;
   logic [AB+STB-1:0]              theta_wide;

   always_comb begin
      a6 = svpwm_pkg::A6_W'({s1_angle_ff, 2'b00}) + svpwm_pkg::A6_W'({s1_angle_ff, 1'b0});
      theta_wide = {a6[AB-1:0], {STB{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_sector_ff   <= svpwm_pkg::sector_type'(a6[svpwm_pkg::A6_W-1:AB]);
      s2_idx_ff      <= theta_wide[AB+STB-1 -: STB];
      s2_dividend_ff <= svpwm_pkg::DVD_W'(s1_mag_ff) * svpwm_pkg::DVD_W'(svpwm_pkg::SQRT3_Q30);
      s2_magsq_ff    <= svpwm_pkg::MAGSQ_W'(s1_mag_ff) * svpwm_pkg::MAGSQ_W'(s1_mag_ff);
   end

   // ---------------- Stage 3: range check and sine ROM read ----------------
   logic                              s3_valid_ff;
   logic [svpwm_pkg::DVD_W-1:0]       s3_dividend_ff;
   svpwm_pkg::div_side_type           s3_side_ff;
   logic [svpwm_pkg::ROM_ADDR_W-1:0]  rom_addr2;
   logic [svpwm_pkg::ROM_ADDR_W-1:0]  rom_addr1;
   logic [svpwm_pkg::TRIPLE_W-1:0]    magsq_x3;
   logic                              s3_fault_in;

   always_comb begin
      rom_addr2   = {1'b0, s2_idx_ff};
      rom_addr1   = svpwm_pkg::ROM_TOP - rom_addr2;
      magsq_x3    = svpwm_pkg::TRIPLE_W'({s2_magsq_ff, 1'b0})
                  + svpwm_pkg::TRIPLE_W'(s2_magsq_ff);
      s3_fault_in = (bus_ff == '0) || (magsq_x3 > svpwm_pkg::TRIPLE_W'(bus_sq_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_dividend_ff    <= s2_dividend_ff;
      s3_side_ff.fault  <= s3_fault_in;
      s3_side_ff.sector <= s2_sector_ff;
      s3_side_ff.sin1   <= svpwm_pkg::SINE_ROM[rom_addr1];
      s3_side_ff.sin2   <= svpwm_pkg::SINE_ROM[rom_addr2];
   end

   // ---------------- Divider: m = |uq| * sqrt3 / bus ----------------
   logic                          dv_valid;
   logic [svpwm_pkg::QUO_W-1:0]   dv_quotient;
   svpwm_pkg::div_side_type       dv_side;

   svpwm_div u_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s3_valid_ff),
      .in_dividend  (s3_dividend_ff),
      .divisor      (bus_ff),
      .in_side      (s3_side_ff),
      .out_valid    (dv_valid),
      .out_quotient (dv_quotient),
      .out_side     (dv_side)
   );

   // ---------------- Ratio stage: r = m * sin ----------------
   logic                         rp_valid_ff;
   logic                         rp_fault_ff;
   svpwm_pkg::sector_type        rp_sector_ff;
   logic [svpwm_pkg::R_W-1:0]    rp_r1_ff;
   logic [svpwm_pkg::R_W-1:0]    rp_r2_ff;
   logic [svpwm_pkg::PROD_W-1:0] prod1;
   logic [svpwm_pkg::PROD_W-1:0] prod2;

   always_comb begin
      prod1 = svpwm_pkg::PROD_W'(dv_quotient) * svpwm_pkg::PROD_W'(dv_side.sin1);
      prod2 = svpwm_pkg::PROD_W'(dv_quotient) * svpwm_pkg::PROD_W'(dv_side.sin2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_valid_ff <= 1'b0;
      end else begin
         rp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      rp_fault_ff  <= dv_side.fault;
      rp_sector_ff <= dv_side.sector;
      rp_r1_ff     <= prod1[svpwm_pkg::R_SHIFT +: svpwm_pkg::R_W];
      rp_r2_ff     <= prod2[svpwm_pkg::R_SHIFT +: svpwm_pkg::R_W];
   end

   // ---------------- Zero-time stage ----------------
   logic                              zt_valid_ff;
   logic                              zt_fault_ff;
   svpwm_pkg::sector_type             zt_sector_ff;
   logic [svpwm_pkg::R_W-1:0]         zt_r1_ff;
   logic [svpwm_pkg::R_W-1:0]         zt_r2_ff;
   logic [svpwm_pkg::R_W-1:0]         zt_zh_ff;
   logic signed [svpwm_pkg::SUM_W-1:0] z_s;
   logic                              z_overmod;
   logic [svpwm_pkg::R_W-1:0]         zt_zh_in;

   always_comb begin
      z_s = $signed(svpwm_pkg::SUM_W'(svpwm_pkg::DUTY_ONE))
          - $signed(svpwm_pkg::SUM_W'(rp_r1_ff))
          - $signed(svpwm_pkg::SUM_W'(rp_r2_ff));
      // Below -1 LSB is over modulation; exactly -1 LSB counts as zero
      z_overmod = z_s < $signed({svpwm_pkg::SUM_W{1'b1}});
      if (z_s[svpwm_pkg::SUM_W-1]) begin
         zt_zh_in = '0;
      end else begin
         zt_zh_in = z_s[svpwm_pkg::R_W:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zt_valid_ff <= 1'b0;
      end else begin
         zt_valid_ff <= rp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      zt_fault_ff  <= rp_fault_ff || z_overmod;
      zt_sector_ff <= rp_sector_ff;
      zt_r1_ff     <= rp_r1_ff;
      zt_r2_ff     <= rp_r2_ff;
      zt_zh_ff     <= zt_zh_in;
   end

   // ---------------- Output stage: centred duty table ----------------
   logic                          out_strobe_ff;
   logic [svpwm_pkg::DUTY_W-1:0]  out_a_ff;
   logic [svpwm_pkg::DUTY_W-1:0]  out_b_ff;
   logic [svpwm_pkg::DUTY_W-1:0]  out_c_ff;
   logic                          out_ok_ff;
   logic [svpwm_pkg::SUM_W-1:0]   sum_all;
   logic [svpwm_pkg::SUM_W-1:0]   sum_r1;
   logic [svpwm_pkg::SUM_W-1:0]   sum_r2;
   logic [svpwm_pkg::SUM_W-1:0]   sum_z;
   logic [svpwm_pkg::SUM_W-1:0]   da;
   logic [svpwm_pkg::SUM_W-1:0]   db;
   logic [svpwm_pkg::SUM_W-1:0]   dc;
   logic [svpwm_pkg::DUTY_W-1:0]  out_a_in;
   logic [svpwm_pkg::DUTY_W-1:0]  out_b_in;
   logic [svpwm_pkg::DUTY_W-1:0]  out_c_in;

   always_comb begin
      sum_z   = svpwm_pkg::SUM_W'(zt_zh_ff);
      sum_r1  = svpwm_pkg::SUM_W'(zt_r1_ff) + sum_z;
      sum_r2  = svpwm_pkg::SUM_W'(zt_r2_ff) + sum_z;
      sum_all = sum_r1 + svpwm_pkg::SUM_W'(zt_r2_ff);
      unique case (zt_sector_ff)
         svpwm_pkg::SEC_1: begin da = sum_all; db = sum_r2;  dc = sum_z;   end
         svpwm_pkg::SEC_2: begin da = sum_r1;  db = sum_all; dc = sum_z;   end
         svpwm_pkg::SEC_3: begin da = sum_z;   db = sum_all; dc = sum_r2;  end
         svpwm_pkg::SEC_4: begin da = sum_z;   db = sum_r1;  dc = sum_all; end
         svpwm_pkg::SEC_5: begin da = sum_r2;  db = sum_z;   dc = sum_all; end
         svpwm_pkg::SEC_6: begin da = sum_all; db = sum_z;   dc = sum_r1;  end
         default:          begin da = '0;      db = '0;      dc = '0;      end
      endcase
      if (zt_fault_ff) begin
         out_a_in = '0;
         out_b_in = '0;
         out_c_in = '0;
      end else begin
         out_a_in = fit_duty(da);
         out_b_in = fit_duty(db);
         out_c_in = fit_duty(dc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_strobe_ff <= 1'b0;
      end else begin
         out_strobe_ff <= zt_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_a_ff  <= out_a_in;
      out_b_ff  <= out_b_in;
      out_c_ff  <= out_c_in;
      out_ok_ff <= !zt_fault_ff;
   end

   assign rsp_strobe    = out_strobe_ff;
   assign rsp_duty_a    = out_a_ff;
   assign rsp_duty_b    = out_b_ff;
   assign rsp_duty_c    = out_c_ff;
   assign rsp_valid_res = out_ok_ff;

endmodule

FILE: design/svpwm_checker.sv
// Port-level checks on the SVPWM duty core, bound to the top level.
module svpwm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_strobe,
   input logic [svpwm_pkg::DUTY_W-1:0]       rsp_duty_a,
   input logic [svpwm_pkg::DUTY_W-1:0]       rsp_duty_b,
   input logic [svpwm_pkg::DUTY_W-1:0]       rsp_duty_c,
   input logic                               rsp_valid_res
);

   // Reset empties the pipe and holds off requests in the cycle after it
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (busy && !rsp_strobe))
      else $error("busy low or strobe high right after reset");

   // Every strobe traces back to an accepted word at fixed latency
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, svpwm_pkg::RSP_LATENCY))
      else $error("response word without a matching request");

   // Every accepted word produces a strobe at fixed latency
   a_req_gets_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(svpwm_pkg::RSP_LATENCY) rsp_strobe)
      else $error("request word lost in the pipeline");

   // An invalid result carries zero duties
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_valid_res) |->
         (rsp_duty_a == '0 && rsp_duty_b == '0 && rsp_duty_c == '0))
      else $error("invalid result with nonzero duty");

endmodule

bind svpwm_duty_from_uq_angle_core svpwm_checker u_svpwm_checker (.*);

FILE: tb/tb_top.sv
// Self-checking testbench for the SVPWM duty core: directed corners plus randomized requests.
module tb_top;

   localparam longint unsigned ROOT3_Q30    = 64'd1859775393;
   localparam longint unsigned THIRD_PI_Q30 = 64'd1124419809;
   localparam longint unsigned FULL_DUTY    = 64'd1 << svpwm_pkg::DUTY_FRAC_BITS;
   localparam int RANDOM_PER_PHASE = 204;
   localparam int PHASES = 9;
   localparam int CYCLE_LIMIT = 200000;

   // Directed corners: zero, range edges, sector midpoints at full modulation,
   // sector edges with a negative voltage
   localparam int DIR_COUNT = 21;
   localparam int DIR_UQ [DIR_COUNT] = '{
      0, 1, -1, 6928, -6928, 6929, -6929, 32767, -32768,
      6928, 6928, 6928, 6928, 6928, 6928,
      -5000, -5000, -5000, -5000, -5000, -5000};
   localparam int DIR_ANGLE [DIR_COUNT] = '{
      0, 1, 65535, 16'h1234, 16'hFEDC, 0, 32768, 65535, 32768,
      54613, 0, 10922, 21845, 32768, 43690,
      16384, 27307, 38230, 49152, 60075, 5462};
   localparam int BUS_PLAN [PHASES] = '{65535, 0, 1, 24000, -1, 6000, 48000, 12000, 57000};

   // Expected content of one response word
   typedef struct {
      logic [svpwm_pkg::DUTY_W-1:0] duty_a;
      logic [svpwm_pkg::DUTY_W-1:0] duty_b;
      logic [svpwm_pkg::DUTY_W-1:0] duty_c;
      logic                         valid_res;
   } duty_set_type;

   // Duty predictor and in-order store of expected duty sets
   class duty_scoreboard_type;
      longint unsigned sine_tab [svpwm_pkg::ROM_DEPTH];
      longint unsigned bus;
      duty_set_type    expected_duties [$];
      int              errors;
      int              n_checked;
      int              n_valid;

      function new();
         longint unsigned x;
         longint unsigned x2;
         longint unsigned term;
         longint unsigned sum;
         bus = 64'(svpwm_pkg::BUS_RESET);
         errors = 0;
         n_checked = 0;
         n_valid = 0;
         // Truncated eight-term Taylor sine over [0, pi/3], Q30
         for (int j = 0; j < svpwm_pkg::ROM_DEPTH; j++) begin
            x    = (longint'(j) * THIRD_PI_Q30) >> svpwm_pkg::SINE_TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int k = 1; k <= 7; k++) begin
               term = (term * x2) >> 30;
               term = term / longint'((2 * k) * (2 * k + 1));
               if (k % 2 == 1) begin
                  sum = sum - term;
               end else begin
                  sum = sum + term;
               end
            end
            sine_tab[j] = sum & 64'h3FFF_FFFF;
         end
      endfunction

      function logic [svpwm_pkg::DUTY_W-1:0] clamp_duty(longint unsigned v);
         if (v > FULL_DUTY) v = FULL_DUTY;
         return v[svpwm_pkg::DUTY_W-1:0];
      endfunction

      function duty_set_type predict_duties(logic [svpwm_pkg::UQ_W-1:0] uq,
                                            logic [svpwm_pkg::ANGLE_W-1:0] ang);
         duty_set_type    r;
         longint unsigned mag;
         longint unsigned amask;
         longint unsigned a;
         longint unsigned sec;
         longint unsigned theta;
         longint unsigned idx;
         longint unsigned m;
         longint unsigned r1;
         longint unsigned r2;
         longint unsigned zh;
         longint unsigned da;
         longint unsigned db;
         longint unsigned dc;
         longint          z;
         r.duty_a = '0;
         r.duty_b = '0;
         r.duty_c = '0;
         r.valid_res = 1'b0;
         mag = uq[svpwm_pkg::UQ_W-1] ? (64'h10000 - {48'd0, uq}) : {48'd0, uq};
         // zero bus or magnitude beyond bus/sqrt3
         if (bus == 0 || 3 * mag * mag > bus * bus) return r;

         // voltage vector angle: quarter turn ahead, half turn more when negative
         amask = (64'd1 << svpwm_pkg::ANGLE_BITS) - 1;
         a = ({48'd0, ang} & amask) + (64'd1 << (svpwm_pkg::ANGLE_BITS - 2));
         if (uq[svpwm_pkg::UQ_W-1]) a = a + (64'd1 << (svpwm_pkg::ANGLE_BITS - 1));
         a = a & amask;
         sec   = (a * 6) >> svpwm_pkg::ANGLE_BITS;
         theta = a * 6 - (sec << svpwm_pkg::ANGLE_BITS);
         idx   = (theta >> (svpwm_pkg::ANGLE_BITS - svpwm_pkg::SINE_TABLE_BITS))
               & ((64'd1 << svpwm_pkg::SINE_TABLE_BITS) - 1);

         // active-vector ratios and half zero-vector time
         m  = (mag * ROOT3_Q30) / bus;
         r1 = (m * sine_tab[(1 << svpwm_pkg::SINE_TABLE_BITS) - idx])
            >> (60 - svpwm_pkg::DUTY_FRAC_BITS);
         r2 = (m * sine_tab[idx]) >> (60 - svpwm_pkg::DUTY_FRAC_BITS);
         z  = longint'(FULL_DUTY) - longint'(r1) - longint'(r2);
         if (z < -1) return r;
         if (z < 0) z = 0;
         zh = $unsigned(z) >> 1;

         unique case (svpwm_pkg::sector_type'(sec[2:0]))
            svpwm_pkg::SEC_1: begin da = r1 + r2 + zh; db = r2 + zh;      dc = zh;      end
            svpwm_pkg::SEC_2: begin da = r1 + zh;      db = r1 + r2 + zh; dc = zh;      end
            svpwm_pkg::SEC_3: begin da = zh;           db = r1 + r2 + zh; dc = r2 + zh; end
            svpwm_pkg::SEC_4: begin da = zh;      db = r1 + zh;      dc = r1 + r2 + zh; end
            svpwm_pkg::SEC_5: begin da = r2 + zh; db = zh;           dc = r1 + r2 + zh; end
            default: begin da = r1 + r2 + zh; db = zh; dc = r1 + zh; end
         endcase
         r.duty_a = clamp_duty(da);
         r.duty_b = clamp_duty(db);
         r.duty_c = clamp_duty(dc);
         r.valid_res = 1'b1;
         return r;
      endfunction

      function void note_request(logic [svpwm_pkg::UQ_W-1:0] uq,
                                 logic [svpwm_pkg::ANGLE_W-1:0] ang);
         expected_duties.push_back(predict_duties(uq, ang));
      endfunction

      function void check_result(logic [svpwm_pkg::DUTY_W-1:0] duty_a,
                                 logic [svpwm_pkg::DUTY_W-1:0] duty_b,
                                 logic [svpwm_pkg::DUTY_W-1:0] duty_c,
                                 logic valid_res);
         duty_set_type want;
         if (expected_duties.size() == 0) begin
            $error("unexpected duty word: a %0d b %0d c %0d valid %0d",
                   duty_a, duty_b, duty_c, valid_res);
            errors++;
            return;
         end
         want = expected_duties.pop_front();
         n_checked++;
         if (want.valid_res) n_valid++;
         if (duty_a !== want.duty_a) begin
            $error("duty_a: expected %0d, actual %0d", want.duty_a, duty_a);
            errors++;
         end
         if (duty_b !== want.duty_b) begin
            $error("duty_b: expected %0d, actual %0d", want.duty_b, duty_b);
            errors++;
         end
         if (duty_c !== want.duty_c) begin
            $error("duty_c: expected %0d, actual %0d", want.duty_c, duty_c);
            errors++;
         end
         if (valid_res !== want.valid_res) begin
            $error("valid_res: expected %0d, actual %0d", want.valid_res, valid_res);
            errors++;
         end
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic [svpwm_pkg::UQ_W-1:0]      req_uq;
   logic [svpwm_pkg::ANGLE_W-1:0]   req_angle;
   logic                            rsp_strobe;
   logic [svpwm_pkg::DUTY_W-1:0]    rsp_duty_a;
   logic [svpwm_pkg::DUTY_W-1:0]    rsp_duty_b;
   logic [svpwm_pkg::DUTY_W-1:0]    rsp_duty_c;
   logic                            rsp_valid_res;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [svpwm_pkg::BUS_W-1:0]     csr_bus_voltage;

   duty_scoreboard_type sb = new();
   int                  cycle_count = 0;
   int                  n_bus_settings = 1;

   svpwm_duty_from_uq_angle_core uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_uq          (req_uq),
      .req_angle       (req_angle),
      .rsp_strobe      (rsp_strobe),
      .rsp_duty_a      (rsp_duty_a),
      .rsp_duty_b      (rsp_duty_b),
      .rsp_duty_c      (rsp_duty_c),
      .rsp_valid_res   (rsp_valid_res),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_bus_voltage (csr_bus_voltage)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         sb.check_result(rsp_duty_a, rsp_duty_b, rsp_duty_c, rsp_valid_res);
      end
   end

   // Run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Send one request word, with random idle cycles ahead of it
   task automatic send_item(input logic [svpwm_pkg::UQ_W-1:0] uq_w,
                            input logic [svpwm_pkg::ANGLE_W-1:0] ang_w,
                            input int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_uq    <= uq_w;
      req_angle <= ang_w;
      do @(posedge clock); while (busy);
      sb.note_request(uq_w, ang_w);
   endtask

   // Stop sending and wait for every outstanding response
   task automatic drain_pipeline();
      start <= 1'b0;
      while (sb.expected_duties.size() != 0) @(posedge clock);
   endtask

   task automatic write_bus(input logic [svpwm_pkg::BUS_W-1:0] value);
      csr_valid       <= 1'b1;
      csr_bus_voltage <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.bus = 64'(value);
      n_bus_settings++;
   endtask

   initial begin
      int          lim;
      int          mag;
      int          pick;
      int          idle_pct;
      int          k;
      int          bus_val;
      bit          neg;
      logic [15:0] uq_w;
      logic [15:0] ang_w;
      reset           = 1'b1;
      start           = 1'b0;
      req_uq          = '0;
      req_angle       = '0;
      csr_valid       = 1'b0;
      csr_bus_voltage = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed corners at the reset bus voltage
      for (int i = 0; i < DIR_COUNT; i++) begin
         send_item(16'(DIR_UQ[i]), 16'(DIR_ANGLE[i]), 0);
      end

      // random phases, one bus voltage each
      for (int ph = 0; ph < PHASES; ph++) begin
         drain_pipeline();
         bus_val = (BUS_PLAN[ph] < 0) ? int'($urandom_range(2, 65534)) : BUS_PLAN[ph];
         write_bus(16'(bus_val));
         idle_pct = (ph < 3) ? 8 : (ph < 6) ? 84 : 0;

         // largest magnitude still inside bus/sqrt3
         lim = int'($sqrt(real'(bus_val) * real'(bus_val) / 3.0));
         while (lim > 0 && 3 * longint'(lim) * lim > longint'(bus_val) * bus_val) lim--;
         while (3 * longint'(lim + 1) * (lim + 1) <= longint'(bus_val) * bus_val) lim++;
         if (lim > 32768) lim = 32768;

         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            pick = int'($urandom_range(0, 99));
            neg  = 1'($urandom_range(0, 1));
            if (pick < 55) begin
               mag = int'($urandom_range(0, lim));
            end else if (pick < 75) begin
               // hug the over-range boundary from both sides
               mag = lim + 1 - int'($urandom_range(0, (lim < 20) ? lim + 1 : 20));
               if (mag > 32768) mag = 32768;
            end else begin
               mag = -1;
            end
            if (mag < 0) begin
               uq_w = 16'($urandom);
            end else begin
               if (mag == 32768) neg = 1'b1;
               uq_w = neg ? 16'(-mag) : 16'(mag);
            end
            if ($urandom_range(0, 99) < 15) begin
               // land close to a sector edge of the voltage vector
               k = int'($urandom_range(0, 5));
               ang_w = 16'((k * 65536 + 5) / 6 - 16384 - (uq_w[15] ? 32768 : 0)
                           + int'($urandom_range(0, 8)) - 4);
            end else begin
               ang_w = 16'($urandom);
            end
            send_item(uq_w, ang_w, idle_pct);
         end
      end

      drain_pipeline();
      repeat (svpwm_pkg::RSP_LATENCY + 4) @(posedge clock);
      if (sb.expected_duties.size() != 0) begin
         $error("%0d duty words never arrived", sb.expected_duties.size());
         sb.errors++;
      end
      $display("Run covered %0d duty words across %0d bus voltages,",
               sb.n_checked, n_bus_settings);
      $display("%0d of them valid and %0d flagged out of range.",
               sb.n_valid, sb.n_checked - sb.n_valid);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
